FILE: rtl/particle_radial_force_top_assert.svh
// Assertion macros for the particle radial force block.
`ifndef PARTICLE_RADIAL_FORCE_TOP_ASSERT_SVH
`define PARTICLE_RADIAL_FORCE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prf assertion failed");
`define PRF_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("prf latency assertion failed");
`else
`define PRF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PRF_ASSERT_DELAY(label, clk, rst, ante, dly, cons)
`endif
`endif

FILE: rtl/prf_pkg.sv
// Shared widths, register codes and payload types for the particle radial force block.
package prf_pkg;
   localparam int POS_W      = 21;
   localparam int DIFF_W     = POS_W + 1;
   localparam int SQ_W       = 44;
   localparam int RADIUS_W   = 20;
   localparam int SCALE_W    = 16;
   localparam int FORCE_W    = 16;
   localparam int EXT_BITS   = 9;
   localparam int SQRT_W     = RADIUS_W + EXT_BITS;
   localparam int QUO_W      = FORCE_W - 1;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd25600;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd256;
   // input capture, squares, sum, root, diff, multiply, divide, multiply, divide, output
   localparam int LATENCY = 3 + SQRT_W + 2 + QUO_W + 1 + QUO_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FORCE_RADIUS = 8'd0,
      CSR_FORCE_SCALE  = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d;
      logic [SQ_W-1:0]        sq;
      logic                   in_range;
   } root_side_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d;
      logic [SQ_W-1:0]        sq;
      logic                   in_range;
      logic [SQRT_W-1:0]      len;
      logic                   neg;
   } mag_side_type;

   typedef struct packed {
      logic [SQ_W-1:0] sq;
      logic            in_range;
      logic            neg;
   } force_side_type;
endpackage

FILE: rtl/particle_radial_force_top.sv
// Top level of the particle radial force block.
//
// Usage: pulse start with a particle and target position on the req_ ports; busy is
// always low, so a new word is taken on every cycle that start is high. Each word gives
// exactly one result, shown on the rsp_ ports for one cycle while rsp_valid is high.
// From the accepting edge to the edge that takes the result, a word passes through
// the offset, square and sum stages, the bit-per-stage square root, the stages
// forming (R - L) * scale, the divider for the magnitude, the multiply stage, the three
// parallel direction dividers and the output stage. Throughput is one word per cycle;
// every stage advances each clock.
// The receiver cannot stall; results appear in input order.
// Radius and scale are written on the csr_ channel (csr_ready is always high); write
// them only while no word is in flight. Reset, synchronous, empties the pipeline and
// loads radius 25600 and scale 256.
`include "particle_radial_force_top_assert.svh"
module particle_radial_force_top import prf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [POS_W-1:0]   req_particle_x,
   input  logic signed [POS_W-1:0]   req_particle_y,
   input  logic signed [POS_W-1:0]   req_particle_z,
   input  logic signed [POS_W-1:0]   req_target_x,
   input  logic signed [POS_W-1:0]   req_target_y,
   input  logic signed [POS_W-1:0]   req_target_z,
   output logic                      rsp_valid,
   output logic signed [FORCE_W-1:0] rsp_force_dx,
   output logic signed [FORCE_W-1:0] rsp_force_dy,
   output logic signed [FORCE_W-1:0] rsp_force_dz,
   output logic                      rsp_in_range,
   output logic [SQ_W-1:0]           rsp_squared_distance,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);
   localparam int PROD_W = DIFF_W + QUO_W;
   localparam int FNUM_W = PROD_W + EXT_BITS;
   localparam int MAG_W  = SQRT_W + SCALE_W;

   // config registers
   logic [RADIUS_W-1:0] radius_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [SQRT_W-1:0]   radius_ext;

   assign csr_ready  = 1'b1;
   assign busy       = 1'b0;
   assign radius_ext = {radius_ff, EXT_BITS'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         scale_ff  <= SCALE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FORCE_RADIUS: radius_ff <= csr_data[RADIUS_W-1:0];
            CSR_FORCE_SCALE:  scale_ff  <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: offsets
   logic                   v1_ff;
   logic [2:0][DIFF_W-1:0] d1_ff, d1_in;

   always_comb begin
      d1_in[0] = DIFF_W'(req_particle_x) - DIFF_W'(req_target_x);
      d1_in[1] = DIFF_W'(req_particle_y) - DIFF_W'(req_target_y);
      d1_in[2] = DIFF_W'(req_particle_z) - DIFF_W'(req_target_z);
   end

   // stage 2: squares and radius squared
   logic                   v2_ff;
   logic [2:0][DIFF_W-1:0] d2_ff;
   logic [2:0][SQ_W-1:0]   sqp2_ff, sqp2_in;
   logic [2*RADIUS_W-1:0]  rsq2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sqp2_in[i] = SQ_W'($signed(d1_ff[i]) * $signed(d1_ff[i]));
      end
   end

   // stage 3: sum and range test
   logic                   v3_ff;
   logic [2:0][DIFF_W-1:0] d3_ff;
   logic [SQ_W-1:0]        sq3_ff, sq3_in;
   logic                   in3_ff, in3_in;

   assign sq3_in = sqp2_ff[0] + sqp2_ff[1] + sqp2_ff[2];
   assign in3_in = (sq3_in != '0) && (sq3_in < SQ_W'(rsq2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff   <= d1_in;
      d2_ff   <= d1_ff;
      sqp2_ff <= sqp2_in;
      rsq2_ff <= radius_ff * radius_ff;
      d3_ff   <= d2_ff;
      sq3_ff  <= sq3_in;
      in3_ff  <= in3_in;
   end

   // root of sq with EXT_BITS extra fraction bits
   root_side_type     root_side_in, root_side_out;
   logic              vr;
   logic [SQRT_W-1:0] len_r;

   assign root_side_in = '{d: d3_ff, sq: sq3_ff, in_range: in3_ff};

   prf_sqrt #(
      .RW (SQRT_W),
      .SW ($bits(root_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_x      ({sq3_ff[2*SQRT_W-2*EXT_BITS-1:0], (2*EXT_BITS)'(0)}),
      .in_side   (root_side_in),
      .out_valid (vr),
      .out_root  (len_r),
      .out_side  (root_side_out)
   );

   // stage 4: R - L and |scale|; stage 5: product
   logic              v4_ff, v5_ff;
   root_side_type     side4_ff, side5_ff;
   logic [SQRT_W-1:0] len4_ff, len5_ff;
   logic [SQRT_W-1:0] diff4_ff;
   logic [SCALE_W-1:0] sabs4_ff;
   logic              neg4_ff, neg5_ff;
   logic [MAG_W-1:0]  prod5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= vr;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      side4_ff <= root_side_out;
      len4_ff  <= len_r;
      diff4_ff <= radius_ext - len_r;
      sabs4_ff <= scale_ff[SCALE_W-1] ? SCALE_W'(-scale_ff) : scale_ff;
      neg4_ff  <= scale_ff[SCALE_W-1];
      side5_ff <= side4_ff;
      len5_ff  <= len4_ff;
      neg5_ff  <= neg4_ff;
      prod5_ff <= MAG_W'(diff4_ff) * MAG_W'(sabs4_ff);
   end

   // magnitude |a| = (R - L) * |scale| / R
   mag_side_type     mag_side_in, mag_side_out;
   logic             va;
   logic [QUO_W-1:0] amag;

   assign mag_side_in = '{d: side5_ff.d, sq: side5_ff.sq, in_range: side5_ff.in_range,
                          len: len5_ff, neg: neg5_ff};

   prf_udiv #(
      .NW (MAG_W),
      .DW (SQRT_W),
      .QW (QUO_W),
      .SW ($bits(mag_side_type))
   ) u_div_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_num    (prod5_ff),
      .in_den    (radius_ext),
      .in_side   (mag_side_in),
      .out_valid (va),
      .out_quo   (amag),
      .out_side  (mag_side_out)
   );

   // stage 6: |d_i| * |a| per axis
   logic                   v6_ff;
   logic [2:0][PROD_W-1:0] prod6_ff, prod6_in;
   logic [2:0]             neg6_ff, neg6_in;
   logic [SQ_W-1:0]        sq6_ff;
   logic                   in6_ff;
   logic [SQRT_W-1:0]      len6_ff;

   always_comb begin
      logic [DIFF_W-1:0] dabs;
      for (int i = 0; i < 3; i++) begin
         dabs        = mag_side_out.d[i][DIFF_W-1] ? DIFF_W'(-mag_side_out.d[i])
                                                   : mag_side_out.d[i];
         prod6_in[i] = PROD_W'(dabs) * PROD_W'(amag);
         neg6_in[i]  = mag_side_out.d[i][DIFF_W-1] ^ mag_side_out.neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= va;
      end
   end

   always_ff @(posedge clock) begin
      prod6_ff <= prod6_in;
      neg6_ff  <= neg6_in;
      sq6_ff   <= mag_side_out.sq;
      in6_ff   <= mag_side_out.in_range;
      len6_ff  <= mag_side_out.len;
   end

   // direction dividers: |d_i| * 2^EXT * |a| / L
   force_side_type   fside_in, fside_out;
   logic             vf0, vf1, vf2;
   logic [QUO_W-1:0] fmag0, fmag1, fmag2;
   logic             fneg1, fneg2;

   assign fside_in = '{sq: sq6_ff, in_range: in6_ff, neg: neg6_ff[0]};

   prf_udiv #(
      .NW (FNUM_W),
      .DW (SQRT_W),
      .QW (QUO_W),
      .SW ($bits(force_side_type))
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    ({prod6_ff[0], EXT_BITS'(0)}),
      .in_den    (len6_ff),
      .in_side   (fside_in),
      .out_valid (vf0),
      .out_quo   (fmag0),
      .out_side  (fside_out)
   );

   prf_udiv #(
      .NW (FNUM_W),
      .DW (SQRT_W),
      .QW (QUO_W),
      .SW (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    ({prod6_ff[1], EXT_BITS'(0)}),
      .in_den    (len6_ff),
      .in_side   (neg6_ff[1]),
      .out_valid (vf1),
      .out_quo   (fmag1),
      .out_side  (fneg1)
   );

   prf_udiv #(
      .NW (FNUM_W),
      .DW (SQRT_W),
      .QW (QUO_W),
      .SW (1)
   ) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    ({prod6_ff[2], EXT_BITS'(0)}),
      .in_den    (len6_ff),
      .in_side   (neg6_ff[2]),
      .out_valid (vf2),
      .out_quo   (fmag2),
      .out_side  (fneg2)
   );

   // output stage: apply sign, zero outside the radius
   logic               rsp_valid_ff;
   logic [FORCE_W-1:0] fx_ff, fy_ff, fz_ff;
   logic               rin_ff;
   logic [SQ_W-1:0]    rsq_ff;
   logic [FORCE_W-1:0] fx_in, fy_in, fz_in;

   always_comb begin
      fx_in = fside_out.neg ? FORCE_W'(-FORCE_W'(fmag0)) : FORCE_W'(fmag0);
      fy_in = fneg1 ? FORCE_W'(-FORCE_W'(fmag1)) : FORCE_W'(fmag1);
      fz_in = fneg2 ? FORCE_W'(-FORCE_W'(fmag2)) : FORCE_W'(fmag2);
      if (!fside_out.in_range) begin
         fx_in = '0;
         fy_in = '0;
         fz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vf0;
      end
   end

   always_ff @(posedge clock) begin
      fx_ff  <= fx_in;
      fy_ff  <= fy_in;
      fz_ff  <= fz_in;
      rin_ff <= fside_out.in_range;
      rsq_ff <= fside_out.sq;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_force_dx         = fx_ff;
   assign rsp_force_dy         = fy_ff;
   assign rsp_force_dz         = fz_ff;
   assign rsp_in_range         = rin_ff;
   assign rsp_squared_distance = rsq_ff;

   `PRF_ASSERT_DELAY(a_latency, clock, reset, start && !busy, LATENCY, rsp_valid)
   `PRF_ASSERT_IMPLY(a_lanes_lockstep, clock, reset, 1'b1, (vf0 == vf1) && (vf0 == vf2))
   `PRF_ASSERT_IMPLY(a_zero_outside, clock, reset, rsp_valid && !rsp_in_range,
      (rsp_force_dx == '0) && (rsp_force_dy == '0) && (rsp_force_dz == '0))
   `PRF_ASSERT_IMPLY(a_inside_nonzero, clock, reset, rsp_valid && rsp_in_range,
      rsp_squared_distance != '0)
endmodule

FILE: rtl/prf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module prf_sqrt import prf_pkg::*; #(
   parameter int RW = SQRT_W,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_x,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);
   localparam int XW = 2 * RW;
   localparam int MW = RW + 2;

   logic [RW-1:0] valid_ff, valid_in;
   logic [MW-1:0] rem_ff  [RW];
   logic [MW-1:0] rem_in  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [RW-1:0] root_in [RW];
   logic [XW-1:0] x_ff    [RW];
   logic [XW-1:0] x_in    [RW];
   logic [SW-1:0] side_ff [RW];
   logic [SW-1:0] side_in [RW];

   always_comb begin
      logic [MW-1:0] rem_src;
      logic [RW-1:0] root_src;
      logic [XW-1:0] x_src;
      logic [MW+1:0] rem_cat;
      logic [MW+1:0] trial;
      logic          fits;
      for (int j = 0; j < RW; j++) begin
         if (j == 0) begin
            rem_src    = '0;
            root_src   = '0;
            x_src      = in_x;
            valid_in[j] = in_valid;
            side_in[j] = in_side;
         end else begin
            rem_src    = rem_ff[j-1];
            root_src   = root_ff[j-1];
            x_src      = x_ff[j-1];
            valid_in[j] = valid_ff[j-1];
            side_in[j] = side_ff[j-1];
         end
         rem_cat    = {rem_src, x_src[XW-1 -: 2]};
         trial      = {2'b00, root_src, 2'b01};
         fits       = (rem_cat >= trial);
         rem_in[j]  = fits ? MW'(rem_cat - trial) : MW'(rem_cat);
         root_in[j] = {root_src[RW-2:0], fits};
         x_in[j]    = x_src << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < RW; j++) begin
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
         x_ff[j]    <= x_in[j];
         side_ff[j] <= side_in[j];
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];
endmodule

FILE: rtl/prf_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module prf_udiv import prf_pkg::*; #(
   parameter int NW = 46,
   parameter int DW = SQRT_W,
   parameter int QW = QUO_W,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [QW-1:0] valid_ff, valid_in;
   logic [NW-1:0] rem_ff  [QW];
   logic [NW-1:0] rem_in  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [DW-1:0] den_in  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [QW-1:0] quo_in  [QW];
   logic [SW-1:0] side_ff [QW];
   logic [SW-1:0] side_in [QW];

   always_comb begin
      logic [NW-1:0] rem_src;
      logic [QW-1:0] quo_src;
      logic [CW-1:0] rem_x;
      logic [CW-1:0] den_sh;
      logic          fits;
      for (int j = 0; j < QW; j++) begin
         if (j == 0) begin
            rem_src     = in_num;
            quo_src     = '0;
            den_in[j]   = in_den;
            valid_in[j] = in_valid;
            side_in[j]  = in_side;
         end else begin
            rem_src     = rem_ff[j-1];
            quo_src     = quo_ff[j-1];
            den_in[j]   = den_ff[j-1];
            valid_in[j] = valid_ff[j-1];
            side_in[j]  = side_ff[j-1];
         end
         rem_x     = CW'(rem_src);
         den_sh    = CW'(den_in[j]) << (QW - 1 - j);
         fits      = (rem_x >= den_sh);
         rem_in[j] = fits ? NW'(rem_x - den_sh) : rem_src;
         quo_in[j] = quo_src | (QW'(fits) << (QW - 1 - j));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         rem_ff[j]  <= rem_in[j];
         den_ff[j]  <= den_in[j];
         quo_ff[j]  <= quo_in[j];
         side_ff[j] <= side_in[j];
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];
endmodule
